// ===== rtl/core/byr_pkg.sv =====
// Shared types and constants for the planar run-length body decoder.
// Used by every module under rtl/core; depends on nothing else.
package byr_pkg;

   // Limits on the effective register values
   localparam int unsigned MAX_PLANES    = 8;
   localparam int unsigned MAX_ROW_BYTES = 1024;
   localparam int unsigned MAX_ROWS      = 4096;

   // Run-length header coding: 128 is a no-op, above it a repeat of 257 - n bytes
   localparam logic [7:0] HDR_NOOP    = 8'h80;
   localparam logic [8:0] REPEAT_BIAS = 9'd257;

   // Register indexes on the configuration port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HAS_MASK    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMPRESSED  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_BYTES   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT   = 3'd4;

   // Effective configuration, already clamped to the legal ranges
   typedef struct packed {
      logic [3:0]  planes;      // colour planes, 1..8
      logic [3:0]  total;       // colour planes plus mask plane, 1..9
      logic        compressed;
      logic [10:0] row_bytes;   // 1..1024
      logic [12:0] rows;        // 1..4096
   } byr_cfg_type;

   // One result item
   typedef struct packed {
      logic [2:0]  plane;
      logic [11:0] row;
      logic [9:0]  column;
      logic [7:0]  value;
      logic [7:0]  repeat_res;
      logic        write_valid;
      logic        frame_end;
      logic        overrun;
   } byr_result_type;

endpackage

// ===== rtl/core/planar_byterun1_body_decoder_core.sv =====
// Top level of the planar run-length body decoder.
// Depends on byr_pkg, byr_csr, byr_decoder and byr_out_queue.
//
//   Channel   Direction  Handshake            Payload
//   req       in         req_valid/req_stall  req_body_byte
//   rsp       out        rsp_valid/rsp_stall  plane, row, column, value, repeat_res,
//                                             write_valid, frame_end, overrun
//   csr       in         csr_valid/csr_ready  csr_index, csr_data
//
// One body byte per cycle while req_stall is low: a byte is held in the input
// register, is decoded and lands in the output register or the skid entry
// behind it. Bytes that cause no result leave nothing.
// Synchronous reset restores the default registers and the frame start.
// Under rsp_stall the skid entry absorbs one more result, then req_stall rises.
module planar_byterun1_body_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_body_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_plane,
   output logic [11:0] rsp_row,
   output logic [9:0]  rsp_column,
   output logic [7:0]  rsp_value,
   output logic [7:0]  rsp_repeat_res,
   output logic        rsp_write_valid,
   output logic        rsp_frame_end,
   output logic        rsp_overrun,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [byr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [byr_pkg::CSR_DATA_W-1:0]  csr_data
);

   byr_pkg::byr_cfg_type    cfg;
   byr_pkg::byr_result_type push_data;
   byr_pkg::byr_result_type head;
   logic                    push;
   logic                    queue_full;

   byr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   byr_decoder u_decoder (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_body_byte (req_body_byte),
      .queue_full    (queue_full),
      .push          (push),
      .push_data     (push_data)
   );

   byr_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   // Split the result item onto its ports
   assign rsp_plane       = head.plane;
   assign rsp_row         = head.row;
   assign rsp_column      = head.column;
   assign rsp_value       = head.value;
   assign rsp_repeat_res  = head.repeat_res;
   assign rsp_write_valid = head.write_valid;
   assign rsp_frame_end   = head.frame_end;
   assign rsp_overrun     = head.overrun;

endmodule

// ===== rtl/core/byr_csr.sv =====
// Configuration registers of the body decoder, stored in clamped form.
// Depends on byr_pkg.
module byr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [byr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [byr_pkg::CSR_DATA_W-1:0]   csr_data,
   output byr_pkg::byr_cfg_type             cfg
);

   logic [3:0]  planes_ff, planes_in;
   logic        mask_ff, mask_in;
   logic        comp_ff, comp_in;
   logic [10:0] rbytes_ff, rbytes_in;
   logic [12:0] rows_ff, rows_in;
   logic        wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;

   // Clamp incoming values and pick the addressed register
   always_comb begin
      planes_in = planes_ff;
      mask_in   = mask_ff;
      comp_in   = comp_ff;
      rbytes_in = rbytes_ff;
      rows_in   = rows_ff;
      if (wr) begin
         unique case (csr_index)
            byr_pkg::CSR_PLANE_COUNT: begin
               if (csr_data[3:0] == 4'd0)
                  planes_in = 4'd1;
               else if (csr_data[3:0] > 4'(byr_pkg::MAX_PLANES))
                  planes_in = 4'(byr_pkg::MAX_PLANES);
               else
                  planes_in = csr_data[3:0];
            end
            byr_pkg::CSR_HAS_MASK:   mask_in = csr_data[0];
            byr_pkg::CSR_COMPRESSED: comp_in = csr_data[0];
            byr_pkg::CSR_ROW_BYTES: begin
               if (csr_data[10:0] == 11'd0)
                  rbytes_in = 11'd1;
               else if (csr_data[10:0] > 11'(byr_pkg::MAX_ROW_BYTES))
                  rbytes_in = 11'(byr_pkg::MAX_ROW_BYTES);
               else
                  rbytes_in = csr_data[10:0];
            end
            byr_pkg::CSR_ROW_COUNT: begin
               if (csr_data[12:0] == 13'd0)
                  rows_in = 13'd1;
               else if (csr_data[12:0] > 13'(byr_pkg::MAX_ROWS))
                  rows_in = 13'(byr_pkg::MAX_ROWS);
               else
                  rows_in = csr_data[12:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         planes_ff <= 4'd5;
         mask_ff   <= 1'b0;
         comp_ff   <= 1'b1;
         rbytes_ff <= 11'd40;
         rows_ff   <= 13'd200;
      end else begin
         planes_ff <= planes_in;
         mask_ff   <= mask_in;
         comp_ff   <= comp_in;
         rbytes_ff <= rbytes_in;
         rows_ff   <= rows_in;
      end
   end

   assign cfg.planes     = planes_ff;
   assign cfg.total      = planes_ff + {3'd0, mask_ff};
   assign cfg.compressed = comp_ff;
   assign cfg.row_bytes  = rbytes_ff;
   assign cfg.rows       = rows_ff;

endmodule

// ===== rtl/core/byr_decoder.sv =====
// Input register, position counters and run-length decode of one byte a cycle while the queue has room.
// Depends on byr_pkg; feeds results to byr_out_queue.
module byr_decoder (
   input  logic                   clock,
   input  logic                   reset,
   input  byr_pkg::byr_cfg_type   cfg,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_body_byte,
   input  logic                   queue_full,
   output logic                   push,
   output byr_pkg::byr_result_type push_data
);

   typedef enum logic [1:0] {
      MODE_HEADER  = 2'd0,
      MODE_LITERAL = 2'd1,
      MODE_REPEAT  = 2'd2
   } mode_type;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     byte_ff;
   logic [3:0]     plane_ff, plane_in;
   logic [11:0]    row_ff, row_in;
   logic [10:0]    col_ff, col_in;
   mode_type       mode_ff, mode_in;
   logic [7:0]     run_ff, run_in;

   logic           accept, advance, colour;
   logic           wv, fe, ov, end_row;
   logic [7:0]     val, rep;
   logic [10:0]    col_step, avail;
   logic [7:0]     fill_n;
   logic [7:0]     run_dec;
   logic [3:0]     plane_inc;
   logic [12:0]    row_inc;
   logic [8:0]     neg_len;

   // Hold the byte until the result queue has room
   assign advance   = in_valid_ff & ~queue_full;
   assign req_stall = in_valid_ff & queue_full;
   assign accept    = req_valid & ~req_stall;

   assign colour    = plane_ff < cfg.planes;
   assign avail     = (col_ff < cfg.row_bytes) ? (cfg.row_bytes - col_ff) : 11'd0;
   assign fill_n    = ({3'd0, run_ff} < avail) ? run_ff : avail[7:0];
   assign run_dec   = run_ff - 8'd1;
   assign plane_inc = plane_ff + 4'd1;
   assign row_inc   = {1'b0, row_ff} + 13'd1;
   assign neg_len   = byr_pkg::REPEAT_BIAS - {1'b0, byte_ff};

   // Decode the held byte and step the position
   always_comb begin
      wv       = 1'b0;
      fe       = 1'b0;
      ov       = 1'b0;
      end_row  = 1'b0;
      val      = 8'd0;
      rep      = 8'd0;
      col_step = col_ff;
      mode_in  = mode_ff;
      run_in   = run_ff;
      plane_in = plane_ff;
      row_in   = row_ff;

      if (!cfg.compressed) begin
         mode_in = MODE_HEADER;
         run_in  = 8'd0;
         if (col_ff < cfg.row_bytes) begin
            wv       = colour;
            val      = byte_ff;
            rep      = 8'd1;
            col_step = col_ff + 11'd1;
         end else begin
            ov = 1'b1;
         end
         end_row = col_step >= cfg.row_bytes;
      end else begin
         unique case (mode_ff)
            MODE_LITERAL: begin
               if (col_ff < cfg.row_bytes) begin
                  wv       = colour;
                  val      = byte_ff;
                  rep      = 8'd1;
                  col_step = col_ff + 11'd1;
               end else begin
                  ov = 1'b1;
               end
               run_in = run_dec;
               if (run_dec == 8'd0) begin
                  mode_in = MODE_HEADER;
                  end_row = col_step >= cfg.row_bytes;
               end
            end
            MODE_REPEAT: begin
               ov = fill_n < run_ff;
               if (fill_n != 8'd0 && colour) begin
                  wv  = 1'b1;
                  val = byte_ff;
                  rep = fill_n;
               end
               col_step = col_ff + {3'd0, fill_n};
               mode_in  = MODE_HEADER;
               run_in   = 8'd0;
               end_row  = col_step >= cfg.row_bytes;
            end
            default: begin
               // Header byte; the no-op header leaves the run count alone
               mode_in = MODE_HEADER;
               if (!byte_ff[7]) begin
                  run_in  = byte_ff + 8'd1;
                  mode_in = MODE_LITERAL;
               end else if (byte_ff != byr_pkg::HDR_NOOP) begin
                  run_in  = neg_len[7:0];
                  mode_in = MODE_REPEAT;
               end
            end
         endcase
      end

      // Wrap to the next plane row, row and frame
      col_in = col_step;
      if (end_row) begin
         col_in = 11'd0;
         if (plane_inc >= cfg.total) begin
            plane_in = 4'd0;
            if (row_inc >= cfg.rows) begin
               row_in = 12'd0;
               fe     = 1'b1;
            end else begin
               row_in = row_inc[11:0];
            end
         end else begin
            plane_in = plane_inc;
         end
      end
   end

   // Build the result item; status-only items carry zero fields
   always_comb begin
      push_data             = '0;
      push_data.write_valid = wv;
      push_data.frame_end   = fe;
      push_data.overrun     = ov;
      if (wv) begin
         push_data.plane      = plane_ff[2:0];
         push_data.row        = row_ff;
         push_data.column     = col_ff[9:0];
         push_data.value      = val;
         push_data.repeat_res = rep;
      end
   end

   assign push = advance & (wv | fe | ov);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept)
         in_valid_in = 1'b1;
      else if (advance)
         in_valid_in = 1'b0;
   end

   // Hold the input byte and the decode state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         plane_ff    <= 4'd0;
         row_ff      <= 12'd0;
         col_ff      <= 11'd0;
         mode_ff     <= MODE_HEADER;
         run_ff      <= 8'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            plane_ff <= plane_in;
            row_ff   <= row_in;
            col_ff   <= col_in;
            mode_ff  <= mode_in;
            run_ff   <= run_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept)
         byte_ff <= req_body_byte;
   end

endmodule

// ===== rtl/core/byr_out_queue.sv =====
// Two-entry result queue: an output register and a skid register behind it.
// Depends on byr_pkg.
module byr_out_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  byr_pkg::byr_result_type push_data,
   output logic                    full,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output byr_pkg::byr_result_type head
);

   logic                    head_valid_ff, head_valid_in;
   logic                    skid_valid_ff, skid_valid_in;
   byr_pkg::byr_result_type head_ff, head_in;
   byr_pkg::byr_result_type skid_ff, skid_in;
   logic                    pop;

   assign pop       = head_valid_ff & ~rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = head_valid_ff;
   assign head      = head_ff;

   // Refill the output register from the skid entry first, then from the decoder
   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (pop || !head_valid_ff) begin
         if (skid_valid_ff) begin
            head_valid_in = 1'b1;
            head_in       = skid_ff;
            skid_valid_in = push;
            skid_in       = push_data;
         end else begin
            head_valid_in = push;
            head_in       = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule
